### src/obav_pkg.sv
`default_nettype none
package obav_pkg;

  localparam int RANGE_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int FIELD_W     = 16;
  localparam int SPEED_W     = 15;
  localparam int RANGE_EXT_W = (RANGE_WIDTH > FIELD_W) ? RANGE_WIDTH : FIELD_W;
  localparam int CFG_IDX_W   = 3;

  // CORDIC datapath: vector in Q.28 with headroom for gain, angle in pi/2^31
  localparam int ATAN_DEPTH = 24;
  localparam int STEP_W     = $clog2(ATAN_DEPTH);
  localparam int VEC_W      = 38;
  localparam int ACC_W      = 34;

  localparam logic [29:0] ATAN_TAB [ATAN_DEPTH] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef enum logic [1:0] {
    CMD_ODOM = 2'd0,
    CMD_SCAN = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ODOM,
    KIND_SCAN,
    KIND_TICK,
    KIND_IDLE
  } kind_t;

  typedef enum logic [1:0] {
    MODE_CHOOSE  = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_RIGHT   = 2'd2,
    MODE_LEFT    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_CLEAR  = 3'd0,
    CFG_SIDE_CLEAR = 3'd1,
    CFG_ESCAPE     = 3'd2,
    CFG_BEAM_CAP   = 3'd3,
    CFG_FWD_SPEED  = 3'd4,
    CFG_TURN_RATE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] fwd_clear;
    logic [FIELD_W-1:0] side_clear;
    logic [FIELD_W-1:0] escape;
    logic [FIELD_W-1:0] beam_cap;
    logic [SPEED_W-1:0] fwd_speed;
    logic [SPEED_W-1:0] turn_rate;
  } cfg_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [FIELD_W-1:0] qw;
    logic signed [FIELD_W-1:0] qx;
    logic signed [FIELD_W-1:0] qy;
    logic signed [FIELD_W-1:0] qz;
    logic [RANGE_WIDTH-1:0]   rc;
    logic [RANGE_WIDTH-1:0]   rl;
    logic [RANGE_WIDTH-1:0]   rr;
  } item_t;

endpackage
`default_nettype wire

### src/obav_front.sv
`default_nettype none
module obav_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [1:0]                             cmd,
  input  logic signed [obav_pkg::FIELD_W-1:0]    quat_w,
  input  logic signed [obav_pkg::FIELD_W-1:0]    quat_x,
  input  logic signed [obav_pkg::FIELD_W-1:0]    quat_y,
  input  logic signed [obav_pkg::FIELD_W-1:0]    quat_z,
  input  logic [obav_pkg::FIELD_W-1:0]           range_center,
  input  logic [obav_pkg::FIELD_W-1:0]           range_left,
  input  logic [obav_pkg::FIELD_W-1:0]           range_right,
  input  logic                                   center_inf,
  input  logic                                   left_inf,
  input  logic                                   right_inf,
  input  logic [obav_pkg::FIELD_W-1:0]           beam_cap_mm,
  output logic                                   q_valid,
  output obav_pkg::item_t                        q_item,
  input  logic                                   q_take
);

  localparam int RW   = obav_pkg::RANGE_WIDTH;
  localparam int REXT = obav_pkg::RANGE_EXT_W;

  obav_pkg::item_t entries [2];
  obav_pkg::item_t incoming;
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            do_push;
  logic            do_pop;

  // infinite beam takes the configured maximum; clamp to stored width
  function automatic logic [RW-1:0] store_range(input logic [obav_pkg::FIELD_W-1:0] r,
                                                input logic inf,
                                                input logic [obav_pkg::FIELD_W-1:0] rmax);
    logic [REXT-1:0] v;
    logic [REXT-1:0] top;
    v   = REXT'(inf ? rmax : r);
    top = REXT'({RW{1'b1}});
    return RW'((v > top) ? top : v);
  endfunction

  always_comb begin
    incoming.qw = quat_w;
    incoming.qx = quat_x;
    incoming.qy = quat_y;
    incoming.qz = quat_z;
    incoming.rc = store_range(range_center, center_inf, beam_cap_mm);
    incoming.rl = store_range(range_left, left_inf, beam_cap_mm);
    incoming.rr = store_range(range_right, right_inf, beam_cap_mm);
    case (cmd)
      obav_pkg::CMD_ODOM: incoming.kind = obav_pkg::KIND_ODOM;
      obav_pkg::CMD_SCAN: incoming.kind = obav_pkg::KIND_SCAN;
      obav_pkg::CMD_TICK: incoming.kind = obav_pkg::KIND_TICK;
      default:            incoming.kind = obav_pkg::KIND_IDLE;
    endcase
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule
`default_nettype wire

### src/obav_cordic.sv
`default_nettype none
module obav_cordic (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic signed [obav_pkg::FIELD_W-1:0]       qw,
  input  logic signed [obav_pkg::FIELD_W-1:0]       qx,
  input  logic signed [obav_pkg::FIELD_W-1:0]       qy,
  input  logic signed [obav_pkg::FIELD_W-1:0]       qz,
  output logic                                      done,
  output logic signed [obav_pkg::ANGLE_WIDTH-1:0]   yaw
);

  localparam int AW    = obav_pkg::ANGLE_WIDTH;
  localparam int VW    = obav_pkg::VEC_W;
  localparam int ACW   = obav_pkg::ACC_W;
  localparam int SW    = obav_pkg::STEP_W;
  localparam int FW    = obav_pkg::FIELD_W;
  localparam int SH    = 32 - AW;
  localparam logic [SW-1:0] LAST_STEP = SW'(obav_pkg::CORDIC_STEPS - 1);
  localparam logic signed [VW-1:0]  ONE_Q28 = VW'(1) <<< 28;
  localparam logic signed [ACW-1:0] PI_ACC  = ACW'(1) <<< 31;
  localparam logic signed [ACW-1:0] RND     = ACW'(1) <<< (31 - AW);
  localparam logic signed [ACW-1:0] HI      = (ACW'(1) <<< (AW - 1)) - ACW'(1);
  localparam logic signed [ACW-1:0] LO      = -(ACW'(1) <<< (AW - 1));

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_SETUP,
    C_ITER,
    C_ROUND,
    C_DONE
  } cstate_t;

  cstate_t                 state;
  logic [2:0]              k;
  logic signed [FW-1:0]    w, x, y, z;
  logic signed [2*FW-1:0]  prod;
  logic signed [2*FW:0]    sacc;
  logic signed [2*FW:0]    cacc;
  logic signed [VW-1:0]    xr, yr;
  logic signed [ACW-1:0]   acc;
  logic [SW-1:0]           step;

  logic signed [FW-1:0]    mul_a, mul_b;
  logic signed [VW-1:0]    s_v, c_v, dx, dy;
  logic signed [ACW-1:0]   tab, rnd;

  always_comb begin
    case (k)
      3'd0:    begin mul_a = w; mul_b = z; end
      3'd1:    begin mul_a = x; mul_b = y; end
      3'd2:    begin mul_a = y; mul_b = y; end
      3'd3:    begin mul_a = z; mul_b = z; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // s = 2(wz+xy), c = 1.0 - 2(y^2+z^2), both Q.28
  assign s_v = $signed({{(VW-2*FW-2){sacc[2*FW]}}, sacc, 1'b0});
  assign c_v = ONE_Q28 - $signed({{(VW-2*FW-2){cacc[2*FW]}}, cacc, 1'b0});

  assign dx  = yr >>> step;
  assign dy  = xr >>> step;
  assign tab = $signed({{(ACW-30){1'b0}}, obav_pkg::ATAN_TAB[step]});
  assign rnd = (acc + RND) >>> SH;

  assign done = (state == C_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      k     <= 3'd0;
      step  <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            w     <= qw;
            x     <= qx;
            y     <= qy;
            z     <= qz;
            k     <= 3'd0;
            state <= C_MUL;
          end
        end
        C_MUL: begin
          prod <= mul_a * mul_b;
          case (k)
            3'd1:    sacc <= (2*FW+1)'(prod);
            3'd2:    sacc <= sacc + (2*FW+1)'(prod);
            3'd3:    cacc <= (2*FW+1)'(prod);
            3'd4:    cacc <= cacc + (2*FW+1)'(prod);
            default: ;
          endcase
          k <= k + 3'd1;
          if (k == 3'd4) state <= C_SETUP;
        end
        C_SETUP: begin
          step <= '0;
          if (s_v == '0) begin
            yaw   <= (c_v < 0) ? AW'(HI) : '0;
            state <= C_DONE;
          end else begin
            if (c_v < 0) begin
              acc <= (s_v > 0) ? PI_ACC : -PI_ACC;
              xr  <= -c_v;
              yr  <= -s_v;
            end else begin
              acc <= '0;
              xr  <= c_v;
              yr  <= s_v;
            end
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (yr >= 0) begin
            xr  <= xr + dx;
            yr  <= yr - dy;
            acc <= acc + tab;
          end else begin
            xr  <= xr - dx;
            yr  <= yr + dy;
            acc <= acc - tab;
          end
          step <= step + SW'(1);
          if (step == LAST_STEP) state <= C_ROUND;
        end
        C_ROUND: begin
          if (rnd > HI) yaw <= AW'(HI);
          else if (rnd < LO) yaw <= AW'(LO);
          else yaw <= AW'(rnd);
          state <= C_DONE;
        end
        C_DONE: begin
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/obav_back.sv
`default_nettype none
module obav_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  obav_pkg::item_t                      q_item,
  output logic                                 q_take,
  input  obav_pkg::cfg_t                       cfg,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 publish,
  output logic [obav_pkg::SPEED_W-1:0]         linear_cmd,
  output logic signed [obav_pkg::FIELD_W-1:0]  angular_cmd,
  output logic [1:0]                           mode
);

  localparam int AW     = obav_pkg::ANGLE_WIDTH;
  localparam int RW     = obav_pkg::RANGE_WIDTH;
  localparam int REXT   = obav_pkg::RANGE_EXT_W;
  localparam int FW     = obav_pkg::FIELD_W;
  localparam int ESC_W  = AW + 1;
  localparam int ESC_UP = (AW >= FW) ? AW - FW : 0;
  localparam int ESC_DN = (AW < FW) ? FW - AW : 0;

  typedef enum logic {
    B_IDLE,
    B_YAW
  } bstate_t;

  bstate_t               state;
  logic                  out_valid;
  obav_pkg::mode_t       drive_mode;
  logic signed [AW-1:0]  heading;
  logic signed [AW-1:0]  start_heading;
  logic [RW-1:0]         rng_c, rng_l, rng_r;

  logic                  cord_done;
  logic signed [AW-1:0]  cord_yaw;

  obav_pkg::mode_t       tick_mode;
  logic                  tick_pub;
  logic [obav_pkg::SPEED_W-1:0] tick_lin;
  logic signed [FW-1:0]  tick_ang;
  logic                  tick_latch;
  logic                  turn_done;
  logic signed [AW:0]    hdiff;
  logic [ESC_W-1:0]      hmag;
  logic [ESC_W-1:0]      esc;
  logic [REXT-1:0]       c_ext, l_ext, r_ext, fwd_ext, side_ext;
  logic signed [FW-1:0]  rate_s;

  assign q_take = (state == B_IDLE) && q_valid && !out_valid;
  assign empty  = !out_valid;

  obav_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (q_take && (q_item.kind == obav_pkg::KIND_ODOM)),
    .qw    (q_item.qw),
    .qx    (q_item.qx),
    .qy    (q_item.qy),
    .qz    (q_item.qz),
    .done  (cord_done),
    .yaw   (cord_yaw)
  );

  // heading change is compared unwrapped
  assign hdiff = (AW+1)'(start_heading) - (AW+1)'(heading);
  assign hmag  = ESC_W'((hdiff < 0) ? -hdiff : hdiff);
  assign esc   = (AW >= FW) ? (ESC_W'(cfg.escape) << ESC_UP) : ESC_W'(cfg.escape >> ESC_DN);
  assign turn_done = (hmag >= esc);

  assign c_ext    = REXT'(rng_c);
  assign l_ext    = REXT'(rng_l);
  assign r_ext    = REXT'(rng_r);
  assign fwd_ext  = REXT'(cfg.fwd_clear);
  assign side_ext = REXT'(cfg.side_clear);
  assign rate_s   = $signed({1'b0, cfg.turn_rate});

  always_comb begin
    tick_mode  = drive_mode;
    tick_pub   = 1'b0;
    tick_lin   = '0;
    tick_ang   = '0;
    tick_latch = 1'b0;
    case (drive_mode)
      obav_pkg::MODE_CHOOSE: begin
        if (c_ext > fwd_ext) begin
          if (l_ext < side_ext) begin
            tick_mode  = obav_pkg::MODE_RIGHT;
            tick_latch = 1'b1;
          end else if (r_ext < side_ext) begin
            tick_mode  = obav_pkg::MODE_LEFT;
            tick_latch = 1'b1;
          end else begin
            tick_mode = obav_pkg::MODE_FORWARD;
          end
        end else if (c_ext < fwd_ext) begin
          tick_mode  = obav_pkg::MODE_RIGHT;
          tick_latch = 1'b1;
        end
      end
      obav_pkg::MODE_FORWARD: begin
        tick_pub  = 1'b1;
        tick_lin  = cfg.fwd_speed;
        tick_mode = obav_pkg::MODE_CHOOSE;
      end
      default: begin
        if (turn_done) begin
          tick_mode = obav_pkg::MODE_CHOOSE;
        end else begin
          tick_pub = 1'b1;
          tick_ang = (drive_mode == obav_pkg::MODE_RIGHT) ? -rate_s : rate_s;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      out_valid     <= 1'b0;
      drive_mode    <= obav_pkg::MODE_CHOOSE;
      heading       <= '0;
      start_heading <= '0;
      rng_c         <= '0;
      rng_l         <= '0;
      rng_r         <= '0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_take) begin
            case (q_item.kind)
              obav_pkg::KIND_ODOM: begin
                state <= B_YAW;
              end
              obav_pkg::KIND_SCAN: begin
                rng_c       <= q_item.rc;
                rng_l       <= q_item.rl;
                rng_r       <= q_item.rr;
                out_valid   <= 1'b1;
                publish     <= 1'b0;
                linear_cmd  <= '0;
                angular_cmd <= '0;
                mode        <= drive_mode;
              end
              obav_pkg::KIND_TICK: begin
                if (tick_latch) start_heading <= heading;
                drive_mode  <= tick_mode;
                out_valid   <= 1'b1;
                publish     <= tick_pub;
                linear_cmd  <= tick_lin;
                angular_cmd <= tick_ang;
                mode        <= tick_mode;
              end
              default: begin
                out_valid   <= 1'b1;
                publish     <= 1'b0;
                linear_cmd  <= '0;
                angular_cmd <= '0;
                mode        <= drive_mode;
              end
            endcase
          end
        end
        B_YAW: begin
          if (cord_done) begin
            heading     <= cord_yaw;
            out_valid   <= 1'b1;
            publish     <= 1'b0;
            linear_cmd  <= '0;
            angular_cmd <= '0;
            mode        <= drive_mode;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_done_in_yaw: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> (state == B_YAW))
    else $error("yaw finished with no odometry item in flight");

  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    q_take |=> (out_valid || state == B_YAW))
    else $error("taken item produced no result and no yaw job");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !publish) |-> (linear_cmd == '0 && angular_cmd == '0))
    else $error("non-publishing item carries a command");

  a_turn_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && angular_cmd != '0) |->
      (mode == obav_pkg::MODE_RIGHT || mode == obav_pkg::MODE_LEFT))
    else $error("angular command outside a turn");

  a_fwd_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && linear_cmd != '0) |-> (publish && mode == obav_pkg::MODE_CHOOSE))
    else $error("linear command not from a forward step");

endmodule
`default_nettype wire

### src/obstacle_avoid_drive_fsm.sv
`default_nettype none
// Reactive obstacle-avoidance drive controller. Items arrive on a queue-style
// port (push/full) and give exactly one result each on the output queue
// (empty/pop). An odometry item is held in the back end by the iterative yaw
// unit: four products through a single 16x16 multiplier, a set-up step,
// CORDIC_STEPS vectoring steps, a rounding step and a hand-over step; when the
// sine term is zero the steps and the rounding are skipped. Scan, tick and
// unused items bypass the yaw unit. Every item also passes through the
// two-item queue between the front end and the back end, and the back end
// takes no new item while a result waits, so after a pop the next item can
// start in the following cycle. With the one-item result register up to three
// items can be held while the result side stalls. Configuration writes are
// registered and must only be made while no item is outstanding.
module obstacle_avoid_drive_fsm (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            cmd,
  input  logic signed [obav_pkg::FIELD_W-1:0]   quat_w,
  input  logic signed [obav_pkg::FIELD_W-1:0]   quat_x,
  input  logic signed [obav_pkg::FIELD_W-1:0]   quat_y,
  input  logic signed [obav_pkg::FIELD_W-1:0]   quat_z,
  input  logic [obav_pkg::FIELD_W-1:0]          range_center,
  input  logic [obav_pkg::FIELD_W-1:0]          range_left,
  input  logic [obav_pkg::FIELD_W-1:0]          range_right,
  input  logic                                  center_inf,
  input  logic                                  left_inf,
  input  logic                                  right_inf,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  publish,
  output logic [obav_pkg::SPEED_W-1:0]          linear_cmd,
  output logic signed [obav_pkg::FIELD_W-1:0]   angular_cmd,
  output logic [1:0]                            mode,
  input  logic                                  cfg_wr,
  input  logic [obav_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [obav_pkg::FIELD_W-1:0]          cfg_data
);

  localparam int SPW = obav_pkg::SPEED_W;

  obav_pkg::cfg_t  cfg;
  logic            q_valid;
  logic            q_take;
  obav_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_clear  <= 16'd700;
      cfg.side_clear <= 16'd600;
      cfg.escape     <= 16'd5461;
      cfg.beam_cap   <= 16'd3500;
      cfg.fwd_speed  <= SPW'(300);
      cfg.turn_rate  <= SPW'(1500);
    end else if (cfg_wr) begin
      case (cfg_index)
        obav_pkg::CFG_FWD_CLEAR:  cfg.fwd_clear  <= cfg_data;
        obav_pkg::CFG_SIDE_CLEAR: cfg.side_clear <= cfg_data;
        obav_pkg::CFG_ESCAPE:     cfg.escape     <= cfg_data;
        obav_pkg::CFG_BEAM_CAP:   cfg.beam_cap   <= cfg_data;
        obav_pkg::CFG_FWD_SPEED:  cfg.fwd_speed  <= cfg_data[SPW-1:0];
        obav_pkg::CFG_TURN_RATE:  cfg.turn_rate  <= cfg_data[SPW-1:0];
        default: ;
      endcase
    end
  end

  obav_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .range_center (range_center),
    .range_left   (range_left),
    .range_right  (range_right),
    .center_inf   (center_inf),
    .left_inf     (left_inf),
    .right_inf    (right_inf),
    .beam_cap_mm  (cfg.beam_cap),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_take       (q_take)
  );

  obav_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take),
    .cfg         (cfg),
    .empty       (empty),
    .pop         (pop),
    .publish     (publish),
    .linear_cmd  (linear_cmd),
    .angular_cmd (angular_cmd),
    .mode        (mode)
  );

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RAND_ITEMS  = 750;
  localparam int PHASES      = 8;
  localparam int CYCLE_LIMIT = 500000;

  // arctangent of 2^-i in units of pi/2^31, rounded
  localparam longint ATAN_PI31 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  typedef struct packed {
    obav_pkg::cmd_t     cmd;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [15:0]        rc;
    logic [15:0]        rl;
    logic [15:0]        rr;
    logic               ci;
    logic               li;
    logic               ri;
  } drive_item_t;

  typedef struct packed {
    logic        publish;
    logic [14:0] linear;
    logic [15:0] angular;
    logic [1:0]  mode;
  } drive_result_t;

  class drive_cmd_board;
    logic [15:0]     fwd_clear, side_clear, escape, beam_cap;
    logic [14:0]     fwd_speed, turn_rate;
    obav_pkg::mode_t drive_mode;
    longint          heading, turn_start;
    logic [15:0]     beam [3];
    drive_result_t   pending_cmds [$];
    int              errors;

    function void reset_state();
      fwd_clear  = 16'd700;
      side_clear = 16'd600;
      escape     = 16'd5461;
      beam_cap   = 16'd3500;
      fwd_speed  = 15'd300;
      turn_rate  = 15'd1500;
      drive_mode = obav_pkg::MODE_CHOOSE;
      heading    = 0;
      turn_start = 0;
      beam       = '{16'd0, 16'd0, 16'd0};
      errors     = 0;
    endfunction

    function void set_reg(obav_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        obav_pkg::CFG_FWD_CLEAR:  fwd_clear  = val;
        obav_pkg::CFG_SIDE_CLEAR: side_clear = val;
        obav_pkg::CFG_ESCAPE:     escape     = val;
        obav_pkg::CFG_BEAM_CAP:   beam_cap   = val;
        obav_pkg::CFG_FWD_SPEED:  fwd_speed  = val[14:0];
        obav_pkg::CFG_TURN_RATE:  turn_rate  = val[14:0];
        default: ;
      endcase
    endfunction

    // atan2(2(wz+xy), 1-2(y^2+z^2)) by CORDIC vectoring, Q.28 vector
    function longint yaw_from_quat(longint w, longint x, longint y, longint z);
      longint s, c, acc, dc, ds;
      s   = 2 * (w * z + x * y);
      c   = (longint'(1) << 28) - 2 * (y * y + z * z);
      acc = 0;
      if (s == 0) return (c >= 0) ? 0 : 32767;
      if (c < 0) begin
        acc = (s >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
        c = -c;
        s = -s;
      end
      for (int i = 0; i < 16; i++) begin
        dc = s >>> i;
        ds = c >>> i;
        if (s >= 0) begin
          c += dc; s -= ds; acc += ATAN_PI31[i];
        end else begin
          c -= dc; s += ds; acc -= ATAN_PI31[i];
        end
      end
      acc = (acc + (longint'(1) << 15)) >>> 16;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return acc;
    endfunction

    function void predict_item(drive_item_t it);
      drive_result_t r;
      longint        d, ang;
      r = '0;
      case (it.cmd)
        obav_pkg::CMD_ODOM: heading = yaw_from_quat(longint'($signed(it.qw)),
                                                    longint'($signed(it.qx)),
                                                    longint'($signed(it.qy)),
                                                    longint'($signed(it.qz)));
        obav_pkg::CMD_SCAN: begin
          beam[0] = it.ci ? beam_cap : it.rc;
          beam[1] = it.li ? beam_cap : it.rl;
          beam[2] = it.ri ? beam_cap : it.rr;
        end
        obav_pkg::CMD_TICK: begin
          case (drive_mode)
            obav_pkg::MODE_CHOOSE: begin
              if (beam[0] > fwd_clear) begin
                if (beam[1] < side_clear) begin
                  turn_start = heading; drive_mode = obav_pkg::MODE_RIGHT;
                end else if (beam[2] < side_clear) begin
                  turn_start = heading; drive_mode = obav_pkg::MODE_LEFT;
                end else begin
                  drive_mode = obav_pkg::MODE_FORWARD;
                end
              end else if (beam[0] < fwd_clear) begin
                turn_start = heading; drive_mode = obav_pkg::MODE_RIGHT;
              end
            end
            obav_pkg::MODE_FORWARD: begin
              r.publish  = 1'b1;
              r.linear   = fwd_speed;
              drive_mode = obav_pkg::MODE_CHOOSE;
            end
            default: begin
              // heading change is deliberately not wrapped
              d = turn_start - heading;
              if (d < 0) d = -d;
              if (d >= longint'(escape)) begin
                drive_mode = obav_pkg::MODE_CHOOSE;
              end else begin
                ang = (drive_mode == obav_pkg::MODE_RIGHT) ? -longint'(turn_rate)
                                                           : longint'(turn_rate);
                r.publish = 1'b1;
                r.angular = ang[15:0];
              end
            end
          endcase
        end
        default: ;
      endcase
      r.mode = drive_mode;
      pending_cmds.push_back(r);
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (pending_cmds.size() == 0) begin
        report("unexpected result, mode", -1, got.mode);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.publish !== want.publish) report("publish", want.publish, got.publish);
      if (got.linear !== want.linear) report("linear_cmd", want.linear, got.linear);
      if (got.angular !== want.angular)
        report("angular_cmd", $signed(want.angular), $signed(got.angular));
      if (got.mode !== want.mode) report("mode", want.mode, got.mode);
    endfunction

    function int outstanding();
      return pending_cmds.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         cmd = obav_pkg::CMD_NONE;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic [15:0]        range_center = '0, range_left = '0, range_right = '0;
  logic               center_inf = 1'b0, left_inf = 1'b0, right_inf = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               publish;
  logic [14:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [1:0]         mode;
  logic               cfg_wr = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  drive_cmd_board board;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  int             cycles = 0;
  real            sim_yaw = 0.0;

  obstacle_avoid_drive_fsm u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .range_center(range_center), .range_left(range_left), .range_right(range_right),
    .center_inf(center_inf), .left_inf(left_inf), .right_inf(right_inf),
    .empty(empty), .pop(pop), .publish(publish), .linear_cmd(linear_cmd),
    .angular_cmd(angular_cmd), .mode(mode),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_result({publish, linear_cmd, angular_cmd, mode});
    pop <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  function automatic drive_item_t noise_item();
    drive_item_t  it;
    logic [127:0] raw;
    raw    = {$urandom, $urandom, $urandom, $urandom};
    it     = raw[$bits(drive_item_t)-1:0];
    it.cmd = obav_pkg::cmd_t'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic logic [15:0] range_near(logic [15:0] thr);
    int v;
    case ($urandom_range(0, 5))
      0: v = thr;
      1: v = int'(thr) - 1;
      2: v = int'(thr) + 1;
      3: v = int'(thr) + int'($urandom_range(0, 400)) - 200;
      4: v = $urandom_range(0, 65535);
      default: v = $urandom_range(0, 1) ? 0 : 65535;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic send_item(drive_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    cmd          <= it.cmd;
    quat_w       <= it.qw;
    quat_x       <= it.qx;
    quat_y       <= it.qy;
    quat_z       <= it.qz;
    range_center <= it.rc;
    range_left   <= it.rl;
    range_right  <= it.rr;
    center_inf   <= it.ci;
    left_inf     <= it.li;
    right_inf    <= it.ri;
    @(posedge clk);
    while (full) @(posedge clk);
    board.predict_item(it);
  endtask

  task automatic send_odom(int w, int x, int y, int z);
    drive_item_t it;
    it = noise_item();
    it.cmd = obav_pkg::CMD_ODOM;
    it.qw = w[15:0]; it.qx = x[15:0]; it.qy = y[15:0]; it.qz = z[15:0];
    send_item(it);
  endtask

  task automatic send_scan(logic [15:0] c, logic [15:0] l, logic [15:0] r,
                           logic ci, logic li, logic ri);
    drive_item_t it;
    it = noise_item();
    it.cmd = obav_pkg::CMD_SCAN;
    it.rc = c; it.rl = l; it.rr = r;
    it.ci = ci; it.li = li; it.ri = ri;
    send_item(it);
  endtask

  task automatic send_kind(obav_pkg::cmd_t k);
    drive_item_t it;
    it = noise_item();
    it.cmd = k;
    send_item(it);
  endtask

  // mostly slow heading drift so turns last a few ticks, plus wild orientations
  task automatic send_random();
    drive_item_t it;
    int          pick, sub;
    it   = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.cmd = obav_pkg::CMD_ODOM;
      sub = $urandom_range(0, 19);
      if (sub < 12) begin
        sim_yaw = sim_yaw + (real'($urandom_range(0, 400)) - 150.0) / 1000.0;
        it.qw = 16'($rtoi($cos(sim_yaw / 2.0) * 16384.0));
        it.qz = 16'($rtoi($sin(sim_yaw / 2.0) * 16384.0));
        it.qx = 16'(int'($urandom_range(0, 200)) - 100);
        it.qy = 16'(int'($urandom_range(0, 200)) - 100);
      end else if (sub < 17) begin
        it.qw = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.qx = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.qy = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.qz = 16'(int'($urandom_range(0, 32768)) - 16384);
      end
    end else if (pick < 60) begin
      it.cmd = obav_pkg::CMD_SCAN;
      it.rc = range_near(board.fwd_clear);
      it.rl = range_near(board.side_clear);
      it.rr = range_near(board.side_clear);
      it.ci = ($urandom_range(0, 4) == 0);
      it.li = ($urandom_range(0, 4) == 0);
      it.ri = ($urandom_range(0, 4) == 0);
    end else if (pick < 95) begin
      it.cmd = obav_pkg::CMD_TICK;
    end else begin
      it.cmd = obav_pkg::CMD_NONE;
    end
    send_item(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(obav_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic configure_phase(int p);
    logic [15:0] vals [6];
    case (p)
      0: vals = '{16'd700, 16'd600, 16'd5461, 16'd3500, 16'd300, 16'd1500};
      1: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF};
      default: vals = '{16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                        16'($urandom_range(0, 16000)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767))};
    endcase
    for (int i = 0; i < 6; i++) write_reg(obav_pkg::cfg_idx_t'(i), vals[i]);
    cfg_wr <= 1'b0;
  endtask

  initial begin
    board = new;
    board.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_kind(obav_pkg::CMD_TICK);                // centre blocked: right turn
    send_kind(obav_pkg::CMD_TICK);                // turning right
    send_odom(11585, 0, 0, 11585);                // yaw +pi/2
    send_kind(obav_pkg::CMD_TICK);                // turn complete
    send_scan(16'd700, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_kind(obav_pkg::CMD_TICK);                // centre on threshold: stay
    send_scan(16'd0, 16'd599, 16'd0, 1'b1, 1'b0, 1'b1);
    send_kind(obav_pkg::CMD_TICK);                // left blocked: right turn
    send_kind(obav_pkg::CMD_TICK);
    send_odom(16384, 0, 0, 0);                    // zero sine, yaw 0
    send_kind(obav_pkg::CMD_TICK);
    send_odom(0, 0, 16384, 0);                    // +pi saturates
    send_odom(0, 16384, 0, 0);
    send_odom(-32768, 32767, -32768, 32767);      // out-of-range quaternion
    send_odom(-16384, -16384, 16384, -16384);
    send_scan(16'hFFFF, 16'd600, 16'd599, 1'b0, 1'b0, 1'b0);
    send_kind(obav_pkg::CMD_TICK);                // right blocked: left turn
    send_kind(obav_pkg::CMD_TICK);
    send_odom(16384, 0, 0, 2000);
    send_kind(obav_pkg::CMD_TICK);
    send_scan(16'd701, 16'd600, 16'd600, 1'b0, 1'b0, 1'b0);
    send_kind(obav_pkg::CMD_TICK);                // clear: forward
    send_kind(obav_pkg::CMD_TICK);                // forward command
    send_kind(obav_pkg::CMD_NONE);
    send_scan(16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) send_random();
      drain();
      rx_stall_pct = 0;
    end

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/obav_pkg.sv
src/obav_front.sv
src/obav_cordic.sv
src/obav_back.sv
src/obstacle_avoid_drive_fsm.sv
tb/testbench.sv
